### hw/rtl/lav_pkg.sv
// lav_pkg: shared types, widths and constants for the look-at view matrix unit.
// No dependencies; imported by lav_unitize, look_at_view_matrix_unit and tb_top.
package lav_pkg;

    localparam int COORD_W   = 32;
    localparam int UNIT_W    = 18;
    localparam int UNIT_BITS = 16;
    localparam int NORM_W    = 30;
    localparam int SQ_STEPS  = NORM_W + 1;
    localparam int DIV_STEPS = UNIT_BITS + 1;

    localparam logic signed [COORD_W-1:0] UP_X_RESET = 32'sd0;
    localparam logic signed [COORD_W-1:0] UP_Y_RESET = 32'sd65536;
    localparam logic signed [COORD_W-1:0] UP_Z_RESET = 32'sd0;

    typedef enum logic [1:0] {
        CFG_UP_X = 2'd0,
        CFG_UP_Y = 2'd1,
        CFG_UP_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic vld;
        logic ok;
    } unit_stat_t;

endpackage

### hw/rtl/lav_unitize.sv
// lav_unitize: pipelined vector normalizer, Q1.16 unit output.
// Stages: magnitude, leading-one, normalize, square, sum, digit sqrt, restoring divide.
// Depends on lav_pkg.
module lav_unitize
    import lav_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 96
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [3*IN_W-1:0]     v,
    input  logic [SIDE_W-1:0]     side_in,
    output unit_stat_t            stat,
    output logic [3*UNIT_W-1:0]   u,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int PW    = $clog2(IN_W);
    localparam int WIDE  = IN_W + NORM_W - 1;
    localparam int SQ_W  = 2 * NORM_W;
    localparam int SUM_W = 2 * SQ_STEPS;
    localparam int REM_W = NORM_W + 4;
    localparam int NUM_W = NORM_W + UNIT_BITS + 1;
    localparam int DR_W  = SQ_STEPS + 1;

    // stage A: magnitudes
    logic              a_vld_reg;
    logic [IN_W-1:0]   a_mag_reg [3];
    logic [2:0]        a_sgn_reg;
    logic [SIDE_W-1:0] a_side_reg;

    // stage B: leading one
    logic              b_vld_reg;
    logic [IN_W-1:0]   b_mag_reg [3];
    logic [PW-1:0]     b_p_reg;
    logic              b_ok_reg;
    logic [2:0]        b_sgn_reg;
    logic [SIDE_W-1:0] b_side_reg;

    // stage C: normalized magnitudes
    logic              c_vld_reg;
    logic [NORM_W-1:0] c_nm_reg [3];
    logic              c_ok_reg;
    logic [2:0]        c_sgn_reg;
    logic [SIDE_W-1:0] c_side_reg;

    // stage D: squares
    logic              d_vld_reg;
    logic [SQ_W-1:0]   d_sq_reg [3];
    logic [NORM_W-1:0] d_nm_reg [3];
    logic              d_ok_reg;
    logic [2:0]        d_sgn_reg;
    logic [SIDE_W-1:0] d_side_reg;

    // square root chain
    logic                sq_vld_reg  [SQ_STEPS+1];
    logic [SUM_W-1:0]    sq_s_reg    [SQ_STEPS+1];
    logic [REM_W-1:0]    sq_rem_reg  [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] sq_r_reg    [SQ_STEPS+1];
    logic [NORM_W-1:0]   sq_nm_reg   [SQ_STEPS+1][3];
    logic                sq_ok_reg   [SQ_STEPS+1];
    logic [2:0]          sq_sgn_reg  [SQ_STEPS+1];
    logic [SIDE_W-1:0]   sq_side_reg [SQ_STEPS+1];

    // divide chain
    logic                 dv_vld_reg  [DIV_STEPS+1];
    logic [NUM_W-1:0]     dv_num_reg  [DIV_STEPS+1][3];
    logic [DR_W-1:0]      dv_rem_reg  [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] dv_q_reg    [DIV_STEPS+1][3];
    logic [SQ_STEPS-1:0]  dv_n_reg    [DIV_STEPS+1];
    logic                 dv_ok_reg   [DIV_STEPS+1];
    logic [2:0]           dv_sgn_reg  [DIV_STEPS+1];
    logic [SIDE_W-1:0]    dv_side_reg [DIV_STEPS+1];

    // final
    logic                f_vld_reg;
    logic                f_ok_reg;
    logic [3*UNIT_W-1:0] f_u_reg;
    logic [SIDE_W-1:0]   f_side_reg;

    logic signed [IN_W-1:0] vin   [3];
    logic [IN_W-1:0]        mag   [3];
    logic [IN_W-1:0]        b_or;
    logic [PW-1:0]          b_p_next;
    logic [WIDE-1:0]        c_wide [3];
    logic [NUM_W-1:0]       num    [3];
    logic [UNIT_W-1:0]      uq     [3];

    genvar k, j;

    generate
        for (k = 0; k < 3; k++) begin : g_lane
            assign vin[k]    = v[k*IN_W +: IN_W];
            assign mag[k]    = vin[k][IN_W-1] ? (IN_W'(~vin[k]) + IN_W'(1)) : IN_W'(vin[k]);
            assign c_wide[k] = {b_mag_reg[k], (NORM_W-1)'(0)} >> b_p_reg;
            assign num[k]    = NUM_W'({sq_nm_reg[SQ_STEPS][k], UNIT_BITS'(0)})
                             + NUM_W'(sq_r_reg[SQ_STEPS] >> 1);
            assign uq[k]     = dv_sgn_reg[DIV_STEPS][k]
                             ? (UNIT_W'(0) - UNIT_W'(dv_q_reg[DIV_STEPS][k]))
                             : UNIT_W'(dv_q_reg[DIV_STEPS][k]);
        end
    endgenerate

    assign b_or = a_mag_reg[0] | a_mag_reg[1] | a_mag_reg[2];

    always_comb
    begin
        b_p_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (b_or[i])
            begin
                b_p_next = PW'(i);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            f_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= mag[i];
                b_mag_reg[i] <= a_mag_reg[i];
                c_nm_reg[i]  <= c_wide[i][NORM_W-1:0];
                d_sq_reg[i]  <= SQ_W'(c_nm_reg[i]) * SQ_W'(c_nm_reg[i]);
                d_nm_reg[i]  <= c_nm_reg[i];
                a_sgn_reg[i] <= vin[i][IN_W-1];
                f_u_reg[i*UNIT_W +: UNIT_W] <= uq[i];
            end
            a_side_reg <= side_in;
            b_p_reg    <= b_p_next;
            b_ok_reg   <= |b_or;
            b_sgn_reg  <= a_sgn_reg;
            b_side_reg <= a_side_reg;
            c_ok_reg   <= b_ok_reg;
            c_sgn_reg  <= b_sgn_reg;
            c_side_reg <= b_side_reg;
            d_ok_reg   <= c_ok_reg;
            d_sgn_reg  <= c_sgn_reg;
            d_side_reg <= c_side_reg;
            f_ok_reg   <= dv_ok_reg[DIV_STEPS];
            f_side_reg <= dv_side_reg[DIV_STEPS];
        end
    end

    // sum of squares enters the root chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_s_reg[0]    <= SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_r_reg[0]    <= '0;
            sq_nm_reg[0]   <= d_nm_reg;
            sq_ok_reg[0]   <= d_ok_reg;
            sq_sgn_reg[0]  <= d_sgn_reg;
            sq_side_reg[0] <= d_side_reg;
        end
    end

    generate
        for (j = 0; j < SQ_STEPS; j++) begin : g_sqrt
            localparam int BI = SQ_STEPS - 1 - j;
            logic [REM_W-1:0] rs;
            logic [REM_W-1:0] trial;
            logic             ge;

            assign rs    = {sq_rem_reg[j][REM_W-3:0], sq_s_reg[j][2*BI+1 -: 2]};
            assign trial = {1'b0, sq_r_reg[j], 2'b01};
            assign ge    = rs >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_vld_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    sq_vld_reg[j+1] <= sq_vld_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_s_reg[j+1]    <= sq_s_reg[j];
                    sq_rem_reg[j+1]  <= ge ? (rs - trial) : rs;
                    sq_r_reg[j+1]    <= {sq_r_reg[j][SQ_STEPS-2:0], ge};
                    sq_nm_reg[j+1]   <= sq_nm_reg[j];
                    sq_ok_reg[j+1]   <= sq_ok_reg[j];
                    sq_sgn_reg[j+1]  <= sq_sgn_reg[j];
                    sq_side_reg[j+1] <= sq_side_reg[j];
                end
            end
        end
    endgenerate

    // divide setup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_num_reg[0][i] <= num[i];
                dv_rem_reg[0][i] <= DR_W'(num[i] >> DIV_STEPS);
                dv_q_reg[0][i]   <= '0;
            end
            dv_n_reg[0]    <= sq_r_reg[SQ_STEPS];
            dv_ok_reg[0]   <= sq_ok_reg[SQ_STEPS];
            dv_sgn_reg[0]  <= sq_sgn_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
        end
    end

    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_div
            localparam int BI = DIV_STEPS - 1 - j;
            logic [DR_W-1:0] rs [3];
            logic            ge [3];

            for (k = 0; k < 3; k++) begin : g_dlane
                assign rs[k] = {dv_rem_reg[j][k][DR_W-2:0], dv_num_reg[j][k][BI]};
                assign ge[k] = rs[k] >= {1'b0, dv_n_reg[j]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_vld_reg[j+1] <= dv_vld_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dv_num_reg[j+1][i] <= dv_num_reg[j][i];
                        dv_rem_reg[j+1][i] <= ge[i] ? (rs[i] - {1'b0, dv_n_reg[j]}) : rs[i];
                        dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][DIV_STEPS-2:0], ge[i]};
                    end
                    dv_n_reg[j+1]    <= dv_n_reg[j];
                    dv_ok_reg[j+1]   <= dv_ok_reg[j];
                    dv_sgn_reg[j+1]  <= dv_sgn_reg[j];
                    dv_side_reg[j+1] <= dv_side_reg[j];
                end
            end
        end
    endgenerate

    assign stat.vld = f_vld_reg;
    assign stat.ok  = f_ok_reg;
    assign u        = f_u_reg;
    assign side_out = f_side_reg;

endmodule

### hw/rtl/look_at_view_matrix_unit.sv
// look_at_view_matrix_unit: right-handed look-at view matrix, fully pipelined.
// Depends on lav_pkg and lav_unitize.
//
// One eye/target transaction is taken every clock cycle unless the output
// stalls; each result passes the input register, three 55-stage normalizers
// built around a bit-per-stage square root and divider, two cross-product
// stages after the first two normalizers, three translation stages. A stall
// on the output freezes the whole pipeline. World up is written through the
// cfg port (index 0..2 = x, y, z) and resets to (0, 1.0, 0); write it only
// while no transaction is in flight. Degenerate geometry yields all zeros.
module look_at_view_matrix_unit
    import lav_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_x/y/z, true_up_x/y/z, back_x/y/z (18b each), shift_x/y/z (32b each), pad
    output logic [263:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int D_W    = COORD_W + 1;
    localparam int P1_W   = UNIT_W + COORD_W;
    localparam int C1_W   = P1_W + 1;
    localparam int P2_W   = 2 * UNIT_W;
    localparam int C2_W   = P2_W + 1;
    localparam int T_W    = P1_W + 2;
    localparam int Q_W    = T_W - UNIT_BITS + 1;
    localparam int VEC_W  = 3 * UNIT_W;
    localparam int EYE_W  = 3 * COORD_W;
    localparam int S2_W   = 1 + VEC_W + EYE_W;
    localparam int S3_W   = 1 + 2 * VEC_W + EYE_W;

    logic en;

    logic signed [COORD_W-1:0] up_x_reg, up_y_reg, up_z_reg;

    // input stage
    logic                   t0_vld_reg;
    logic [3*D_W-1:0]       t0_d_reg;
    logic [EYE_W-1:0]       t0_eye_reg;
    logic signed [D_W-1:0]  d_next [3];

    // first normalizer
    unit_stat_t         u1_stat;
    logic [VEC_W-1:0]   u1_f;
    logic [EYE_W-1:0]   u1_eye;

    // first cross product
    logic                     p1_vld_reg, p1_ok_reg;
    logic signed [P1_W-1:0]   p1_reg [6];
    logic [VEC_W-1:0]         p1_f_reg;
    logic [EYE_W-1:0]         p1_eye_reg;
    logic                     c1_vld_reg;
    logic [3*C1_W-1:0]        c1_reg;
    logic [S2_W-1:0]          c1_side_reg;
    logic signed [UNIT_W-1:0] fv [3];

    // second normalizer
    unit_stat_t       u2_stat;
    logic [VEC_W-1:0] u2_r;
    logic [S2_W-1:0]  u2_side;

    // second cross product
    logic                     p2_vld_reg, p2_ok_reg;
    logic signed [P2_W-1:0]   p2_reg [6];
    logic [VEC_W-1:0]         p2_r_reg;
    logic [VEC_W-1:0]         p2_f_reg;
    logic [EYE_W-1:0]         p2_eye_reg;
    logic                     c2_vld_reg;
    logic [3*C2_W-1:0]        c2_reg;
    logic [S3_W-1:0]          c2_side_reg;
    logic signed [UNIT_W-1:0] rv [3];
    logic signed [UNIT_W-1:0] f2v [3];

    // third normalizer
    unit_stat_t       u3_stat;
    logic [VEC_W-1:0] u3_u;
    logic [S3_W-1:0]  u3_side;

    // translation
    logic                      t1_vld_reg, t1_ok_reg;
    logic signed [P1_W-1:0]    t1_p_reg [9];
    logic [VEC_W-1:0]          t1_r_reg, t1_u_reg, t1_f_reg;
    logic                      t2_vld_reg, t2_ok_reg;
    logic signed [T_W-1:0]     t2_s_reg [3];
    logic [VEC_W-1:0]          t2_r_reg, t2_u_reg, t2_f_reg;
    logic signed [UNIT_W-1:0]  r3 [3];
    logic signed [UNIT_W-1:0]  u3 [3];
    logic signed [UNIT_W-1:0]  f3 [3];
    logic signed [COORD_W-1:0] e3 [3];
    logic signed [UNIT_W-1:0]  back_v [3];

    logic         m_tvalid_reg;
    logic [263:0] m_tdata_reg;
    logic [263:0] m_tdata_next;

    function automatic logic [COORD_W-1:0] round_sat(input logic signed [T_W-1:0] s);
        logic [T_W-1:0] a;
        logic [Q_W-1:0] q;
        logic [COORD_W-1:0] res;
        a = s[T_W-1] ? (T_W'(0) - T_W'(s)) : T_W'(s);
        q = Q_W'((a + T_W'(1 << (UNIT_BITS - 1))) >> UNIT_BITS);
        if (!s[T_W-1])
        begin
            res = (q > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[COORD_W-1:0];
        end
        else
        begin
            res = (q > Q_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                   : (COORD_W'(0) - q[COORD_W-1:0]);
        end
        return res;
    endfunction

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= UP_X_RESET;
            up_y_reg <= UP_Y_RESET;
            up_z_reg <= UP_Z_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_UP_X: up_x_reg <= cfg_wdata;
                CFG_UP_Y: up_y_reg <= cfg_wdata;
                CFG_UP_Z: up_z_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_vec
            assign d_next[k] = D_W'($signed(s_tdata[(k+3)*COORD_W +: COORD_W]))
                             - D_W'($signed(s_tdata[k*COORD_W +: COORD_W]));
            assign fv[k]     = u1_f[k*UNIT_W +: UNIT_W];
            assign rv[k]     = u2_r[k*UNIT_W +: UNIT_W];
            assign f2v[k]    = u2_side[EYE_W + k*UNIT_W +: UNIT_W];
            assign r3[k]     = u3_side[EYE_W + VEC_W + k*UNIT_W +: UNIT_W];
            assign f3[k]     = u3_side[EYE_W + k*UNIT_W +: UNIT_W];
            assign u3[k]     = u3_u[k*UNIT_W +: UNIT_W];
            assign e3[k]     = u3_side[k*COORD_W +: COORD_W];
            assign back_v[k] = UNIT_W'(0) - t2_f_reg[k*UNIT_W +: UNIT_W];
        end
    endgenerate

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_vld_reg   <= 1'b0;
            p1_vld_reg   <= 1'b0;
            c1_vld_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            c2_vld_reg   <= 1'b0;
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_vld_reg   <= s_tvalid;
            p1_vld_reg   <= u1_stat.vld;
            c1_vld_reg   <= p1_vld_reg;
            p2_vld_reg   <= u2_stat.vld;
            c2_vld_reg   <= p2_vld_reg;
            t1_vld_reg   <= u3_stat.vld;
            t2_vld_reg   <= t1_vld_reg;
            m_tvalid_reg <= t2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t0_d_reg[i*D_W +: D_W] <= d_next[i];
            end
            t0_eye_reg <= s_tdata[EYE_W-1:0];

            p1_reg[0]  <= fv[1] * up_z_reg;
            p1_reg[1]  <= fv[2] * up_y_reg;
            p1_reg[2]  <= fv[2] * up_x_reg;
            p1_reg[3]  <= fv[0] * up_z_reg;
            p1_reg[4]  <= fv[0] * up_y_reg;
            p1_reg[5]  <= fv[1] * up_x_reg;
            p1_ok_reg  <= u1_stat.ok;
            p1_f_reg   <= u1_f;
            p1_eye_reg <= u1_eye;

            c1_reg[0*C1_W +: C1_W] <= C1_W'(p1_reg[0]) - C1_W'(p1_reg[1]);
            c1_reg[1*C1_W +: C1_W] <= C1_W'(p1_reg[2]) - C1_W'(p1_reg[3]);
            c1_reg[2*C1_W +: C1_W] <= C1_W'(p1_reg[4]) - C1_W'(p1_reg[5]);
            c1_side_reg <= {p1_ok_reg, p1_f_reg, p1_eye_reg};

            p2_reg[0]  <= rv[1] * f2v[2];
            p2_reg[1]  <= rv[2] * f2v[1];
            p2_reg[2]  <= rv[2] * f2v[0];
            p2_reg[3]  <= rv[0] * f2v[2];
            p2_reg[4]  <= rv[0] * f2v[1];
            p2_reg[5]  <= rv[1] * f2v[0];
            p2_ok_reg  <= u2_stat.ok && u2_side[S2_W-1];
            p2_r_reg   <= u2_r;
            p2_f_reg   <= u2_side[EYE_W +: VEC_W];
            p2_eye_reg <= u2_side[EYE_W-1:0];

            c2_reg[0*C2_W +: C2_W] <= C2_W'(p2_reg[0]) - C2_W'(p2_reg[1]);
            c2_reg[1*C2_W +: C2_W] <= C2_W'(p2_reg[2]) - C2_W'(p2_reg[3]);
            c2_reg[2*C2_W +: C2_W] <= C2_W'(p2_reg[4]) - C2_W'(p2_reg[5]);
            c2_side_reg <= {p2_ok_reg, p2_r_reg, p2_f_reg, p2_eye_reg};

            for (int i = 0; i < 3; i++)
            begin
                t1_p_reg[i]     <= r3[i] * e3[i];
                t1_p_reg[3 + i] <= u3[i] * e3[i];
                t1_p_reg[6 + i] <= f3[i] * e3[i];
            end
            t1_ok_reg <= u3_stat.ok && u3_side[S3_W-1];
            t1_r_reg  <= u3_side[EYE_W + VEC_W +: VEC_W];
            t1_u_reg  <= u3_u;
            t1_f_reg  <= u3_side[EYE_W +: VEC_W];

            t2_s_reg[0] <= T_W'(0) - (T_W'(t1_p_reg[0]) + T_W'(t1_p_reg[1]) + T_W'(t1_p_reg[2]));
            t2_s_reg[1] <= T_W'(0) - (T_W'(t1_p_reg[3]) + T_W'(t1_p_reg[4]) + T_W'(t1_p_reg[5]));
            t2_s_reg[2] <= T_W'(t1_p_reg[6]) + T_W'(t1_p_reg[7]) + T_W'(t1_p_reg[8]);
            t2_ok_reg   <= t1_ok_reg;
            t2_r_reg    <= t1_r_reg;
            t2_u_reg    <= t1_u_reg;
            t2_f_reg    <= t1_f_reg;

            m_tdata_reg <= m_tdata_next;
        end
    end

    always_comb
    begin
        m_tdata_next = '0;
        if (t2_ok_reg)
        begin
            m_tdata_next[VEC_W-1:0]         = t2_r_reg;
            m_tdata_next[2*VEC_W-1:VEC_W]   = t2_u_reg;
            for (int i = 0; i < 3; i++)
            begin
                m_tdata_next[2*VEC_W + i*UNIT_W +: UNIT_W]  = back_v[i];
                m_tdata_next[3*VEC_W + i*COORD_W +: COORD_W] = round_sat(t2_s_reg[i]);
            end
        end
    end

    lav_unitize #(
        .IN_W   (D_W),
        .SIDE_W (EYE_W)
    ) u_unit_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (t0_vld_reg),
        .v        (t0_d_reg),
        .side_in  (t0_eye_reg),
        .stat     (u1_stat),
        .u        (u1_f),
        .side_out (u1_eye)
    );

    lav_unitize #(
        .IN_W   (C1_W),
        .SIDE_W (S2_W)
    ) u_unit_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c1_vld_reg),
        .v        (c1_reg),
        .side_in  (c1_side_reg),
        .stat     (u2_stat),
        .u        (u2_r),
        .side_out (u2_side)
    );

    lav_unitize #(
        .IN_W   (C2_W),
        .SIDE_W (S3_W)
    ) u_unit_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c2_vld_reg),
        .v        (c2_reg),
        .side_in  (c2_side_reg),
        .stat     (u3_stat),
        .u        (u3_u),
        .side_out (u3_side)
    );

    logic signed [UNIT_W-1:0] chk_right_x;
    logic signed [UNIT_W-1:0] chk_back_z;
    assign chk_right_x = m_tdata[UNIT_W-1:0];
    assign chk_back_z  = m_tdata[3*VEC_W-1 -: UNIT_W];

    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (chk_right_x >= -18'sd65536 && chk_right_x <= 18'sd65536))
        else $error("right_x out of unit range");

    a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (chk_back_z >= -18'sd65536 && chk_back_z <= 18'sd65536))
        else $error("back_z out of unit range");

    a_zero_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3*VEC_W-1:0] == '0) |-> (m_tdata[263:3*VEC_W] == '0))
        else $error("translation nonzero with zero rotation");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (t2_vld_reg && m_tvalid && !m_tready) |=> t2_vld_reg)
        else $error("pipeline advanced during stall");

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for look_at_view_matrix_unit (look-at view matrix).
// Needs lav_pkg and the unit RTL. It runs directed and random eye/target items
// through a fixed-point predictor and compares every result field.
module tb_top
    import lav_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 173;
    localparam int WD_LIMIT = 4000;
    localparam int RES_W    = 258;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [263:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = CFG_UP_X;
    logic [31:0]  cfg_wdata = '0;

    logic signed [31:0] wup[3];
    logic [RES_W-1:0]   matrix_q[$];
    int                 err_cnt = 0;
    int                 sent_cnt = 0;
    int                 got_cnt = 0;
    int                 degen_cnt = 0;
    int                 idle_cycles = 0;
    int                 hold_cnt = 0;
    bit                 no_gaps = 0;

    look_at_view_matrix_unit u_top (.*);

    always #10 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic longint unsigned isqrt(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        longint unsigned mag[3], m, sum, n, q;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        u = '{0, 0, 0};
        if (m == 0) return 0;
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        n = isqrt(sum);
        if (n == 0) return 0;
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << UNIT_BITS) + (n >> 1)) / n;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [31:0] shift_term(input longint r[3], input longint e[3],
                                               input bit neg);
        longint s, val;
        longint unsigned a, q;
        s = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
        if (neg) s = -s;
        a = s < 0 ? -s : s;
        q = (a + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
        val = s < 0 ? -longint'(q) : longint'(q);
        if (val > 64'sd2147483647) val = 64'sd2147483647;
        if (val < -64'sd2147483648) val = -64'sd2147483648;
        return val[31:0];
    endfunction

    function automatic logic [RES_W-1:0] view_matrix(input logic [191:0] d);
        longint eye[3], dir[3], up[3], f[3], c1[3], r[3], c2[3], u[3];
        logic [RES_W-1:0] res;
        longint nf;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(d[32*i +: 32]));
            dir[i] = longint'($signed(d[32*(i+3) +: 32])) - eye[i];
            up[i]  = longint'(wup[i]);
        end
        if (!unit_vec(dir, f)) return res;
        cross_prod(f, up, c1);
        if (!unit_vec(c1, r)) return res;
        cross_prod(r, f, c2);
        if (!unit_vec(c2, u)) return res;
        for (int i = 0; i < 3; i++)
        begin
            nf = -f[i];
            res[18*i +: 18]     = r[i][17:0];
            res[18*(i+3) +: 18] = u[i][17:0];
            res[18*(i+6) +: 18] = nf[17:0];
        end
        res[162 +: 32] = shift_term(r, eye, 1);
        res[194 +: 32] = shift_term(u, eye, 1);
        res[226 +: 32] = shift_term(f, eye, 0);
        return res;
    endfunction

    // ---------------- scoreboard ----------------
    always @(posedge clk)
    begin
        logic [RES_W-1:0] exp_v;
        int w, off;
        if (s_tvalid && s_tready)
        begin
            exp_v = view_matrix(s_tdata);
            if (exp_v == '0) degen_cnt++;
            matrix_q.push_back(exp_v);
        end
        if (m_tvalid && m_tready)
        begin
            got_cnt++;
            if (matrix_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result %h", m_tdata);
            end
            else
            begin
                exp_v = matrix_q.pop_front();
                for (int k = 0; k < 12; k++)
                begin
                    w   = k < 9 ? 18 : 32;
                    off = k < 9 ? 18 * k : 162 + 32 * (k - 9);
                    if ((m_tdata[off +: 32] & ((64'd1 << w) - 1)) !=
                        (exp_v[off +: 32] & ((64'd1 << w) - 1)))
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("result %0d field %0d: exp %h got %h", got_cnt, k,
                                     exp_v[off +: 32] & ((64'd1 << w) - 1),
                                     m_tdata[off +: 32] & ((64'd1 << w) - 1));
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we ||
            (!s_tvalid && matrix_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- output back-pressure ----------------
    always @(posedge clk)
    begin
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps)
            m_tready <= 1'b1;
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (p < 3)
        begin
            hold_cnt <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
        else if (!m_tready)
            m_tready <= (p < 70);
        else
            m_tready <= !(p < 15);
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_view(input logic [31:0] ex, ey, ez, tx, ty, tz);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {tz, ty, tx, ez, ey, ex};
        do @(posedge clk); while (!s_tready);
        sent_cnt++;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (matrix_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_up(input logic [31:0] x, y, z);
        drain();
        cfg_we <= 1'b1; cfg_addr <= CFG_UP_X; cfg_wdata <= x; @(posedge clk);
        wup[0] = x;
        cfg_addr <= CFG_UP_Y; cfg_wdata <= y; @(posedge clk);
        wup[1] = y;
        cfg_addr <= CFG_UP_Z; cfg_wdata <= z; @(posedge clk);
        wup[2] = z;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $urandom();
        if (p < 8) return $signed($urandom_range(0, 2000000)) - 1000000;
        return p == 8 ? 32'h7fffffff : 32'h80000000;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_view(0, 0, 0, 0, 0, 0);
        send_view(32'h12345678, 32'h80000000, 32'h7fffffff, 32'h12345678,
                  32'h80000000, 32'h7fffffff);
        send_view(0, 0, 0, 32'h00010000, 0, 0);
        send_view(0, 0, 0, 0, 0, 32'hffff0000);
        send_view(0, 0, 0, 0, 32'h00050000, 0);
        send_view(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
        send_view(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_view(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000);
        send_view(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
        send_view(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h80000000);
        send_view(1, 0, 0, 0, 0, 0);
        send_view(0, 0, 0, 1, 1, 1);
        send_view(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
        send_view(32'h00030000, 32'h00040000, 32'h00050000,
                  32'h00030000, 32'h00000000, 32'h00050000);
    endtask

    task automatic test_up_settings();
        write_up(0, 0, 0);
        send_view(0, 0, 0, 32'h00010000, 0, 0);
        send_view(5, 6, 7, 32'h7fffffff, 32'h80000000, 3);
        write_up(32'h80000000, 32'h80000000, 32'h80000000);
        send_view(0, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000);
        send_view(0, 0, 0, 32'h00010000, 0, 0);
        send_view(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 32'h00020000);
        write_up(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_view(0, 0, 0, 0, 0, 32'h00010000);
        send_view(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
        write_up(0, 0, 1);
        send_view(0, 0, 0, 32'h00010000, 0, 0);
        send_view(32'h00100000, 32'hfff00000, 32'h7fffffff, 0, 0, 0);
    endtask

    task automatic test_random(input int n);
        logic [31:0] e[3], t[3];
        int p, k;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < 3; j++)
            begin
                e[j] = rand_coord();
                t[j] = rand_coord();
            end
            p = $urandom_range(0, 19);
            if (p == 0)
                t = e;
            else if (p == 1)
            begin
                // target straight along world up from the eye
                k = $urandom_range(1, 8);
                for (int j = 0; j < 3; j++)
                    t[j] = e[j] + 32'(wup[j] >>> k);
            end
            send_view(e[0], e[1], e[2], t[0], t[1], t[2]);
        end
        no_gaps = 0;
    endtask

    initial
    begin
        wup[0] = UP_X_RESET;
        wup[1] = UP_Y_RESET;
        wup[2] = UP_Z_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_up_settings();
        write_up(UP_X_RESET, UP_Y_RESET, UP_Z_RESET);
        test_random(300);
        write_up($urandom(), $urandom(), $urandom());
        test_random(250);
        write_up($signed($urandom_range(0, 131072)) - 65536,
                 $signed($urandom_range(0, 131072)) - 65536,
                 $signed($urandom_range(0, 131072)) - 65536);
        test_random(250);
        write_up(0, 0, 32'hffff0000);
        test_random(120);
        drain();
        repeat (LATENCY * 2) @(posedge clk);
        if (matrix_q.size() != 0)
        begin
            err_cnt++;
            $display("%0d expected results never arrived", matrix_q.size());
        end
        $display("sent %0d eye/target transactions, checked %0d results", sent_cnt, got_cnt);
        $display("%0d degenerate cases, several world-up settings incl. extremes", degen_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
